@@ sv/bsab_pkg.sv @@
// Package for the bilinear scaler with alpha blend.
// Holds sizes, field widths, register indexes and the divide-by-255 helper.
// No dependencies.
package bsab_pkg;

    localparam int SRC_MAX_WIDTH  = 128;
    localparam int SRC_MAX_HEIGHT = 128;
    localparam int FRAC_BITS      = 16;

    localparam int COL_W   = $clog2(SRC_MAX_WIDTH);
    localparam int ROW_W   = $clog2(SRC_MAX_HEIGHT);
    localparam int POS_W   = 10;
    localparam int STEP_W  = 24;
    localparam int ORG_W   = 7;
    localparam int SIZE_W  = 8;
    localparam int CH_W    = 8;
    localparam int TEX_W   = 4 * CH_W;
    localparam int P_W     = POS_W + STEP_W + 1;
    localparam int IP_W    = P_W - FRAC_BITS;
    localparam int WGT_W   = FRAC_BITS + 1;
    localparam int VERT_W  = CH_W + FRAC_BITS;
    localparam int SUM_W   = CH_W + 2 * FRAC_BITS;
    localparam int BANK_AW = (COL_W - 1) + (ROW_W - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [WGT_W-1:0] FIX_ONE = WGT_W'(1) << FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_X       = 3'd0,
        REG_STEP_Y       = 3'd1,
        REG_ORIGIN_X     = 3'd2,
        REG_ORIGIN_Y     = 3'd3,
        REG_SRC_WIDTH    = 3'd4,
        REG_SRC_HEIGHT   = 3'd5,
        REG_GLOBAL_ALPHA = 3'd6,
        REG_FORMAT_MODE  = 3'd7
    } cfg_reg_t;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_BLEND = 1'b1;

    typedef logic [CH_W-1:0] chan_t;
    typedef chan_t [3:0] pix_t;

    // Exact x / 255 for any x below 65280.
    function automatic chan_t div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + 17'(x[15:8]);
        return t[15:8];
    endfunction

endpackage

@@ sv/bsab_if.sv @@
// Channel interfaces for the bilinear scaler: pixel input, pixel output and
// configuration write. Depends on bsab_pkg.
interface bsab_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [bsab_pkg::POS_W-1:0]    pos_x;
    logic [bsab_pkg::POS_W-1:0]    pos_y;
    logic [bsab_pkg::CH_W-1:0]     in_blue;
    logic [bsab_pkg::CH_W-1:0]     in_green;
    logic [bsab_pkg::CH_W-1:0]     in_red;
    logic [bsab_pkg::CH_W-1:0]     in_alpha;
    modport source (output valid, func, pos_x, pos_y, in_blue, in_green, in_red, in_alpha,
                    input ready);
    modport sink (input valid, func, pos_x, pos_y, in_blue, in_green, in_red, in_alpha,
                  output ready);
endinterface

interface bsab_out_if;
    logic                      valid;
    logic                      ready;
    logic [bsab_pkg::CH_W-1:0] out_blue;
    logic [bsab_pkg::CH_W-1:0] out_green;
    logic [bsab_pkg::CH_W-1:0] out_red;
    logic [bsab_pkg::CH_W-1:0] out_alpha;
    modport source (output valid, out_blue, out_green, out_red, out_alpha, input ready);
    modport sink (input valid, out_blue, out_green, out_red, out_alpha, output ready);
endinterface

interface bsab_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bsab_pkg::CFG_IDX_W-1:0]  index;
    logic [bsab_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/bilinear_scale_alpha_blend.sv @@
// Throughput: one item per cycle; the pipeline advances whenever the output
// register is empty or being taken, so a stall holds every stage in place.
// The texel store sits in four banks by row and column parity, so the four
// neighbours are read in the same cycle. Reset clears the configuration
// registers and valid bits; the data registers and texel store are not cleared.
// Depends on bsab_pkg and the interfaces in bsab_if.sv.
module bilinear_scale_alpha_blend (
    input  logic         clk,
    input  logic         rst_n,
    bsab_cfg_if.sink     cfg,
    bsab_in_if.sink      pixel_in,
    bsab_out_if.source   pixel_out
);

    // Configuration registers.
    logic [bsab_pkg::STEP_W-1:0] step_x_reg, step_y_reg;
    logic [bsab_pkg::ORG_W-1:0]  origin_x_reg, origin_y_reg;
    logic [bsab_pkg::SIZE_W-1:0] src_width_reg, src_height_reg;
    logic [bsab_pkg::CH_W-1:0]   global_alpha_reg;
    logic [1:0]                  format_mode_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_x_reg       <= bsab_pkg::STEP_W'(1 << bsab_pkg::FRAC_BITS);
            step_y_reg       <= bsab_pkg::STEP_W'(1 << bsab_pkg::FRAC_BITS);
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            src_width_reg    <= bsab_pkg::SIZE_W'(bsab_pkg::SRC_MAX_WIDTH);
            src_height_reg   <= bsab_pkg::SIZE_W'(bsab_pkg::SRC_MAX_HEIGHT);
            global_alpha_reg <= 8'd255;
            format_mode_reg  <= 2'd3;
        end
        else if (cfg.valid)
        begin
            case (bsab_pkg::cfg_reg_t'(cfg.index))
                bsab_pkg::REG_STEP_X:       step_x_reg <= cfg.data;
                bsab_pkg::REG_STEP_Y:       step_y_reg <= cfg.data;
                bsab_pkg::REG_ORIGIN_X:     origin_x_reg <= cfg.data[bsab_pkg::ORG_W-1:0];
                bsab_pkg::REG_ORIGIN_Y:     origin_y_reg <= cfg.data[bsab_pkg::ORG_W-1:0];
                bsab_pkg::REG_SRC_WIDTH:    src_width_reg <= cfg.data[bsab_pkg::SIZE_W-1:0];
                bsab_pkg::REG_SRC_HEIGHT:   src_height_reg <= cfg.data[bsab_pkg::SIZE_W-1:0];
                bsab_pkg::REG_GLOBAL_ALPHA: global_alpha_reg <= cfg.data[bsab_pkg::CH_W-1:0];
                bsab_pkg::REG_FORMAT_MODE:  format_mode_reg <= cfg.data[1:0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic out_valid_reg;
    assign adv            = !out_valid_reg || pixel_out.ready;
    assign pixel_in.ready = adv;

    // Stage 1: fixed-point source position, or a pending texel load.
    logic                          v1_reg, load1_reg;
    logic [bsab_pkg::P_W-1:0]      px1_reg, py1_reg;
    logic [bsab_pkg::POS_W-1:0]    lx1_reg, ly1_reg;
    bsab_pkg::pix_t                d1_reg;
    logic [bsab_pkg::P_W-1:0]      px1_next, py1_next;

    always_comb
    begin
        px1_next = (bsab_pkg::P_W'(origin_x_reg) << bsab_pkg::FRAC_BITS)
                 + bsab_pkg::P_W'(pixel_in.pos_x) * bsab_pkg::P_W'(step_x_reg);
        py1_next = (bsab_pkg::P_W'(origin_y_reg) << bsab_pkg::FRAC_BITS)
                 + bsab_pkg::P_W'(pixel_in.pos_y) * bsab_pkg::P_W'(step_y_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            load1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= pixel_in.valid && (pixel_in.func == bsab_pkg::FUNC_BLEND);
            load1_reg <= pixel_in.valid && (pixel_in.func == bsab_pkg::FUNC_LOAD)
                         && (32'(pixel_in.pos_x) < bsab_pkg::SRC_MAX_WIDTH)
                         && (32'(pixel_in.pos_y) < bsab_pkg::SRC_MAX_HEIGHT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px1_reg <= px1_next;
            py1_reg <= py1_next;
            lx1_reg <= pixel_in.pos_x;
            ly1_reg <= pixel_in.pos_y;
            d1_reg  <= {pixel_in.in_alpha, pixel_in.in_red, pixel_in.in_green,
                        pixel_in.in_blue};
        end
    end

    // Stage 2: integer coordinates clamped to the source edge.
    logic                          v2_reg;
    logic [bsab_pkg::COL_W-1:0]    x0_reg, x1_reg;
    logic [bsab_pkg::ROW_W-1:0]    y0_reg, y1_reg;
    logic [bsab_pkg::FRAC_BITS-1:0] fx2_reg, fy2_reg;
    bsab_pkg::pix_t                d2_reg;
    logic [bsab_pkg::COL_W-1:0]    x0_next, x1_next, xlast;
    logic [bsab_pkg::ROW_W-1:0]    y0_next, y1_next, ylast;
    logic [bsab_pkg::IP_W-1:0]     ipx, ipy;

    always_comb
    begin
        if (src_width_reg == '0)
            xlast = '0;
        else if (32'(src_width_reg) > bsab_pkg::SRC_MAX_WIDTH)
            xlast = bsab_pkg::COL_W'(bsab_pkg::SRC_MAX_WIDTH - 1);
        else
            xlast = bsab_pkg::COL_W'(src_width_reg - 8'd1);
        if (src_height_reg == '0)
            ylast = '0;
        else if (32'(src_height_reg) > bsab_pkg::SRC_MAX_HEIGHT)
            ylast = bsab_pkg::ROW_W'(bsab_pkg::SRC_MAX_HEIGHT - 1);
        else
            ylast = bsab_pkg::ROW_W'(src_height_reg - 8'd1);
        ipx = px1_reg[bsab_pkg::P_W-1:bsab_pkg::FRAC_BITS];
        ipy = py1_reg[bsab_pkg::P_W-1:bsab_pkg::FRAC_BITS];
        x0_next = (ipx > bsab_pkg::IP_W'(xlast)) ? xlast : ipx[bsab_pkg::COL_W-1:0];
        y0_next = (ipy > bsab_pkg::IP_W'(ylast)) ? ylast : ipy[bsab_pkg::ROW_W-1:0];
        x1_next = (x0_next == xlast) ? xlast : x0_next + 1'b1;
        y1_next = (y0_next == ylast) ? ylast : y0_next + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg  <= x0_next;
            x1_reg  <= x1_next;
            y0_reg  <= y0_next;
            y1_reg  <= y1_next;
            fx2_reg <= px1_reg[bsab_pkg::FRAC_BITS-1:0];
            fy2_reg <= py1_reg[bsab_pkg::FRAC_BITS-1:0];
            d2_reg  <= d1_reg;
        end
    end

    // Texel store in four banks, indexed by row parity then column parity.
    // Neighbours with the same parity are the same clamped texel, so each bank
    // needs one read per cycle.
    logic [bsab_pkg::TEX_W-1:0] bank_q [2][2];
    logic [bsab_pkg::COL_W-1:0] col_sel [2];
    logic [bsab_pkg::ROW_W-1:0] row_sel [2];
    logic [bsab_pkg::TEX_W-1:0] wdata;

    assign wdata = d1_reg;

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            col_sel[c] = (x0_reg[0] == 1'(c)) ? x0_reg : x1_reg;
            row_sel[c] = (y0_reg[0] == 1'(c)) ? y0_reg : y1_reg;
        end
    end

    for (genvar r = 0; r < 2; r++)
    begin : g_row
        for (genvar c = 0; c < 2; c++)
        begin : g_col
            logic [bsab_pkg::TEX_W-1:0] mem [bsab_pkg::BANK_DEPTH];
            logic [bsab_pkg::BANK_AW-1:0] waddr, raddr;
            logic we;
            assign waddr = {ly1_reg[bsab_pkg::ROW_W-1:1], lx1_reg[bsab_pkg::COL_W-1:1]};
            assign raddr = {row_sel[r][bsab_pkg::ROW_W-1:1], col_sel[c][bsab_pkg::COL_W-1:1]};
            assign we = adv && load1_reg && (ly1_reg[0] == 1'(r)) && (lx1_reg[0] == 1'(c));

            always_ff @(posedge clk)
            begin
                if (we)
                    mem[waddr] <= wdata;
                if (adv)
                    bank_q[r][c] <= mem[raddr];
            end
        end
    end

    // Stage 3: texels ready, vertical interpolation.
    logic                           v3_reg;
    logic                           x0p_reg, x1p_reg, y0p_reg, y1p_reg;
    logic [bsab_pkg::FRAC_BITS-1:0] fx3_reg, fy3_reg;
    bsab_pkg::pix_t                 d3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0p_reg <= x0_reg[0];
            x1p_reg <= x1_reg[0];
            y0p_reg <= y0_reg[0];
            y1p_reg <= y1_reg[0];
            fx3_reg <= fx2_reg;
            fy3_reg <= fy2_reg;
            d3_reg  <= d2_reg;
        end
    end

    bsab_pkg::pix_t tl, tr, bl, br;
    logic [bsab_pkg::WGT_W-1:0] wy0, wy1;
    logic [bsab_pkg::VERT_W-1:0] left_next [4], right_next [4];

    always_comb
    begin
        tl  = bank_q[y0p_reg][x0p_reg];
        tr  = bank_q[y0p_reg][x1p_reg];
        bl  = bank_q[y1p_reg][x0p_reg];
        br  = bank_q[y1p_reg][x1p_reg];
        wy1 = bsab_pkg::WGT_W'(fy3_reg);
        wy0 = bsab_pkg::FIX_ONE - wy1;
        for (int k = 0; k < 4; k++)
        begin
            left_next[k]  = bsab_pkg::VERT_W'(tl[k] * wy0) + bsab_pkg::VERT_W'(bl[k] * wy1);
            right_next[k] = bsab_pkg::VERT_W'(tr[k] * wy0) + bsab_pkg::VERT_W'(br[k] * wy1);
        end
    end

    // Stage 4: horizontal interpolation.
    logic                           v4_reg;
    logic [bsab_pkg::VERT_W-1:0]    left_reg [4], right_reg [4];
    logic [bsab_pkg::FRAC_BITS-1:0] fx4_reg;
    bsab_pkg::pix_t                 d4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            fx4_reg   <= fx3_reg;
            d4_reg    <= d3_reg;
        end
    end

    logic [bsab_pkg::WGT_W-1:0] wx0, wx1;
    logic [bsab_pkg::SUM_W-1:0] sum [4];
    bsab_pkg::pix_t             s_next;

    always_comb
    begin
        wx1 = bsab_pkg::WGT_W'(fx4_reg);
        wx0 = bsab_pkg::FIX_ONE - wx1;
        for (int k = 0; k < 4; k++)
        begin
            sum[k] = bsab_pkg::SUM_W'(left_reg[k] * wx0) + bsab_pkg::SUM_W'(right_reg[k] * wx1);
            s_next[k] = sum[k][2*bsab_pkg::FRAC_BITS +: bsab_pkg::CH_W];
        end
    end

    // Stage 5: effective alpha.
    logic           v5_reg;
    bsab_pkg::pix_t s5_reg, d5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (adv)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_reg <= s_next;
            d5_reg <= d4_reg;
        end
    end

    // Without source alpha the global alpha blends directly; at 255 that
    // reproduces a plain copy.
    bsab_pkg::chan_t a_next;
    always_comb
    begin
        if (format_mode_reg[0])
            a_next = bsab_pkg::div255(16'(s5_reg[3] * global_alpha_reg));
        else
            a_next = global_alpha_reg;
    end

    // Stage 6: colour blend.
    logic            v6_reg;
    bsab_pkg::pix_t  s6_reg, d6_reg;
    bsab_pkg::chan_t a6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (adv)
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_reg <= s5_reg;
            d6_reg <= d5_reg;
            a6_reg <= a_next;
        end
    end

    bsab_pkg::pix_t o_next;
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            o_next[k] = bsab_pkg::div255(16'(s6_reg[k] * a6_reg)
                                       + 16'(d6_reg[k] * (8'd255 - a6_reg)));
        if ((format_mode_reg == 2'd3) && (a6_reg > d6_reg[3]))
            o_next[3] = a6_reg;
        else
            o_next[3] = d6_reg[3];
    end

    // Output register.
    bsab_pkg::pix_t o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            o_reg <= o_next;
    end

    assign pixel_out.valid     = out_valid_reg;
    assign pixel_out.out_blue  = o_reg[0];
    assign pixel_out.out_green = o_reg[1];
    assign pixel_out.out_red   = o_reg[2];
    assign pixel_out.out_alpha = o_reg[3];

endmodule

@@ tb/bilinear_scale_alpha_blend_tb.sv @@
// Testbench for the bilinear scaler with alpha blend: random and directed
// texel loads and pixel blends, checked against a predictor held here.
// Depends on bsab_pkg, the interfaces in bsab_if.sv and the top level.
`timescale 1ns / 1ps

module bilinear_scale_alpha_blend_tb;

    typedef struct {
        logic            func;
        logic [9:0]      pos_x;
        logic [9:0]      pos_y;
        logic [7:0]      blue;
        logic [7:0]      green;
        logic [7:0]      red;
        logic [7:0]      alpha;
    } pixel_item_t;

    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
    } bgra_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bsab_cfg_if cfg ();
    bsab_in_if  pixel_in ();
    bsab_out_if pixel_out ();

    bilinear_scale_alpha_blend u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pixel_in  (pixel_in),
        .pixel_out (pixel_out)
    );

    always #5 clk = ~clk;

    // Predictor state: texel store and register copies.
    logic [31:0]    texel_mem [bsab_pkg::SRC_MAX_WIDTH*bsab_pkg::SRC_MAX_HEIGHT];
    bit             planned_written [bsab_pkg::SRC_MAX_WIDTH*bsab_pkg::SRC_MAX_HEIGHT];
    logic [23:0]    reg_val [8];

    pixel_item_t    pending_items [$];
    bgra_t          expected_pixels [$];
    int             error_count = 0;
    int             queued_count = 0;

    pixel_item_t    cur_item;
    logic           in_taken = 1'b0;
    logic           out_taken = 1'b0;
    int             in_gap = 0;
    int             out_stall = 0;
    bit             in_burst = 1'b0;
    bit             out_burst = 1'b0;

    function automatic void locate_axis(input longint unsigned org, input longint unsigned pos,
                                        input longint unsigned step,
                                        input longint unsigned size,
                                        input longint unsigned max_size,
                                        output int i0, output int i1,
                                        output longint unsigned frac);
        longint unsigned p;
        longint unsigned ip;
        longint unsigned lim;
        p = (org << bsab_pkg::FRAC_BITS) + pos * step;
        ip = p >> bsab_pkg::FRAC_BITS;
        lim = size;
        if (lim < 1)
            lim = 1;
        if (lim > max_size)
            lim = max_size;
        if (ip > lim - 1)
            ip = lim - 1;
        i0 = int'(ip);
        i1 = (ip + 1 > lim - 1) ? int'(lim - 1) : int'(ip + 1);
        frac = p & ((64'd1 << bsab_pkg::FRAC_BITS) - 1);
    endfunction

    function automatic void neighbor_indexes(input logic [9:0] px, input logic [9:0] py,
                                             output int idx [4],
                                             output longint unsigned fx,
                                             output longint unsigned fy);
        int x0, x1, y0, y1;
        locate_axis(64'(reg_val[bsab_pkg::REG_ORIGIN_X] & 24'h7F), 64'(px),
                    64'(reg_val[bsab_pkg::REG_STEP_X]),
                    64'(reg_val[bsab_pkg::REG_SRC_WIDTH] & 24'hFF),
                    64'(bsab_pkg::SRC_MAX_WIDTH), x0, x1, fx);
        locate_axis(64'(reg_val[bsab_pkg::REG_ORIGIN_Y] & 24'h7F), 64'(py),
                    64'(reg_val[bsab_pkg::REG_STEP_Y]),
                    64'(reg_val[bsab_pkg::REG_SRC_HEIGHT] & 24'hFF),
                    64'(bsab_pkg::SRC_MAX_HEIGHT), y0, y1, fy);
        idx[0] = y0 * bsab_pkg::SRC_MAX_WIDTH + x0;
        idx[1] = y0 * bsab_pkg::SRC_MAX_WIDTH + x1;
        idx[2] = y1 * bsab_pkg::SRC_MAX_WIDTH + x0;
        idx[3] = y1 * bsab_pkg::SRC_MAX_WIDTH + x1;
    endfunction

    function automatic logic [7:0] mix_channel(input int s, input int d, input int a);
        return 8'((s * a + d * (255 - a)) / 255);
    endfunction

    // Runs one accepted item through the predictor.
    function automatic void apply_item(input pixel_item_t it);
        int                idx [4];
        longint unsigned   fx, fy, one, left, right, sum;
        int                s [4];
        int                d [4];
        int                a, ga;
        logic [1:0]        mode;
        bgra_t             res;
        d[0] = int'(it.blue);
        d[1] = int'(it.green);
        d[2] = int'(it.red);
        d[3] = int'(it.alpha);
        if (it.func == bsab_pkg::FUNC_LOAD)
        begin
            if (it.pos_x < bsab_pkg::SRC_MAX_WIDTH && it.pos_y < bsab_pkg::SRC_MAX_HEIGHT)
                texel_mem[it.pos_y * bsab_pkg::SRC_MAX_WIDTH + it.pos_x] =
                    {it.alpha, it.red, it.green, it.blue};
            return;
        end
        neighbor_indexes(it.pos_x, it.pos_y, idx, fx, fy);
        one = 64'd1 << bsab_pkg::FRAC_BITS;
        for (int k = 0; k < 4; k++)
        begin
            left = 64'(texel_mem[idx[0]][8*k +: 8]) * (one - fy)
                 + 64'(texel_mem[idx[2]][8*k +: 8]) * fy;
            right = 64'(texel_mem[idx[1]][8*k +: 8]) * (one - fy)
                  + 64'(texel_mem[idx[3]][8*k +: 8]) * fy;
            sum = left * (one - fx) + right * fx;
            s[k] = int'((sum >> (2 * bsab_pkg::FRAC_BITS)) & 64'hFF);
        end
        ga = int'(reg_val[bsab_pkg::REG_GLOBAL_ALPHA] & 24'hFF);
        mode = reg_val[bsab_pkg::REG_FORMAT_MODE][1:0];
        if (mode[0])
        begin
            a = s[3] * ga / 255;
            res.blue = mix_channel(s[0], d[0], a);
            res.green = mix_channel(s[1], d[1], a);
            res.red = mix_channel(s[2], d[2], a);
            res.alpha = (mode[1] && a > d[3]) ? 8'(a) : 8'(d[3]);
        end
        else if (ga < 255)
        begin
            res.blue = mix_channel(s[0], d[0], ga);
            res.green = mix_channel(s[1], d[1], ga);
            res.red = mix_channel(s[2], d[2], ga);
            res.alpha = 8'(d[3]);
        end
        else
        begin
            res.blue = 8'(s[0]);
            res.green = 8'(s[1]);
            res.red = 8'(s[2]);
            res.alpha = 8'(d[3]);
        end
        expected_pixels.push_back(res);
    endfunction

    function automatic void queue_load(input int px, input int py,
                                       input logic [31:0] texel);
        pixel_item_t it;
        it.func = bsab_pkg::FUNC_LOAD;
        it.pos_x = 10'(px);
        it.pos_y = 10'(py);
        {it.alpha, it.red, it.green, it.blue} = texel;
        if (px < bsab_pkg::SRC_MAX_WIDTH && py < bsab_pkg::SRC_MAX_HEIGHT)
            planned_written[py * bsab_pkg::SRC_MAX_WIDTH + px] = 1'b1;
        pending_items.push_back(it);
        queued_count++;
    endfunction

    // Queues a blend, preceded by loads of any neighbor not yet written.
    function automatic void queue_blend(input int px, input int py, input logic [31:0] dst);
        pixel_item_t        it;
        int                 idx [4];
        longint unsigned    fx, fy;
        neighbor_indexes(10'(px), 10'(py), idx, fx, fy);
        for (int k = 0; k < 4; k++)
            if (!planned_written[idx[k]])
                queue_load(idx[k] % bsab_pkg::SRC_MAX_WIDTH, idx[k] / bsab_pkg::SRC_MAX_WIDTH,
                           $urandom);
        it.func = bsab_pkg::FUNC_BLEND;
        it.pos_x = 10'(px);
        it.pos_y = 10'(py);
        {it.alpha, it.red, it.green, it.blue} = dst;
        pending_items.push_back(it);
        queued_count++;
    endfunction

    task automatic write_reg(input bsab_pkg::cfg_reg_t index, input logic [23:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        reg_val[index] = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || pixel_in.valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_config(input logic [23:0] sx, input logic [23:0] sy,
                              input logic [23:0] ox, input logic [23:0] oy,
                              input logic [23:0] w, input logic [23:0] h,
                              input logic [23:0] ga, input logic [23:0] mode);
        wait_idle();
        write_reg(bsab_pkg::REG_STEP_X, sx);
        write_reg(bsab_pkg::REG_STEP_Y, sy);
        write_reg(bsab_pkg::REG_ORIGIN_X, ox);
        write_reg(bsab_pkg::REG_ORIGIN_Y, oy);
        write_reg(bsab_pkg::REG_SRC_WIDTH, w);
        write_reg(bsab_pkg::REG_SRC_HEIGHT, h);
        write_reg(bsab_pkg::REG_GLOBAL_ALPHA, ga);
        write_reg(bsab_pkg::REG_FORMAT_MODE, mode);
        in_burst = ($urandom_range(0, 3) == 0);
        out_burst = ($urandom_range(0, 3) == 0);
    endtask

    function automatic logic [23:0] pick_step();
        case ($urandom_range(0, 3))
            0: return 24'd65536;
            1: return 24'($urandom_range(0, 131072));
            2: return 24'($urandom_range(0, 24'h800000));
            default: return 24'($urandom_range(0, 40000));
        endcase
    endfunction

    function automatic logic [23:0] pick_size();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 255));
            1: return 24'($urandom_range(0, 1) ? 0 : 255);
            default: return 24'($urandom_range(1, 12));
        endcase
    endfunction

    // Input driver.
    always @(posedge clk)
    begin
        in_taken <= rst_n && pixel_in.valid && pixel_in.ready;
        if (rst_n && pixel_in.valid && pixel_in.ready)
            apply_item(cur_item);
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pixel_in.valid <= 1'b0;
        end
        else if (pixel_in.valid && !in_taken)
        begin
            // Hold the item until its transfer.
        end
        else
        begin
            if (in_taken)
                in_gap = in_burst ? 0 : $urandom_range(0, 19);
            if (in_gap > 0)
            begin
                in_gap--;
                pixel_in.valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                cur_item = pending_items.pop_front();
                pixel_in.func <= cur_item.func;
                pixel_in.pos_x <= cur_item.pos_x;
                pixel_in.pos_y <= cur_item.pos_y;
                pixel_in.in_blue <= cur_item.blue;
                pixel_in.in_green <= cur_item.green;
                pixel_in.in_red <= cur_item.red;
                pixel_in.in_alpha <= cur_item.alpha;
                pixel_in.valid <= 1'b1;
            end
            else
            begin
                pixel_in.valid <= 1'b0;
            end
        end
    end

    // Output monitor and ready stalls.
    always @(posedge clk)
    begin
        bgra_t exp_px;
        out_taken <= rst_n && pixel_out.valid && pixel_out.ready;
        if (rst_n && pixel_out.valid && pixel_out.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected pixel b=%0d g=%0d r=%0d a=%0d", pixel_out.out_blue,
                       pixel_out.out_green, pixel_out.out_red, pixel_out.out_alpha);
                error_count++;
            end
            else
            begin
                exp_px = expected_pixels.pop_front();
                if (pixel_out.out_blue !== exp_px.blue)
                begin
                    $error("out_blue expected %0d got %0d", exp_px.blue, pixel_out.out_blue);
                    error_count++;
                end
                if (pixel_out.out_green !== exp_px.green)
                begin
                    $error("out_green expected %0d got %0d", exp_px.green, pixel_out.out_green);
                    error_count++;
                end
                if (pixel_out.out_red !== exp_px.red)
                begin
                    $error("out_red expected %0d got %0d", exp_px.red, pixel_out.out_red);
                    error_count++;
                end
                if (pixel_out.out_alpha !== exp_px.alpha)
                begin
                    $error("out_alpha expected %0d got %0d", exp_px.alpha, pixel_out.out_alpha);
                    error_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (out_taken)
            out_stall = out_burst ? 0 : $urandom_range(0, 19);
        if (out_stall > 0)
        begin
            out_stall--;
            pixel_out.ready <= 1'b0;
        end
        else
        begin
            pixel_out.ready <= 1'b1;
        end
    end

    initial
    begin
        #10ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int px, py;
        cfg.valid = 1'b0;
        cfg.index = bsab_pkg::REG_STEP_X;
        cfg.data = '0;
        pixel_in.valid = 1'b0;
        pixel_in.func = bsab_pkg::FUNC_LOAD;
        pixel_in.pos_x = '0;
        pixel_in.pos_y = '0;
        pixel_in.in_blue = '0;
        pixel_in.in_green = '0;
        pixel_in.in_red = '0;
        pixel_in.in_alpha = '0;
        pixel_out.ready = 1'b0;
        reg_val[bsab_pkg::REG_STEP_X] = 24'd65536;
        reg_val[bsab_pkg::REG_STEP_Y] = 24'd65536;
        reg_val[bsab_pkg::REG_ORIGIN_X] = 24'd0;
        reg_val[bsab_pkg::REG_ORIGIN_Y] = 24'd0;
        reg_val[bsab_pkg::REG_SRC_WIDTH] = 24'd128;
        reg_val[bsab_pkg::REG_SRC_HEIGHT] = 24'd128;
        reg_val[bsab_pkg::REG_GLOBAL_ALPHA] = 24'd255;
        reg_val[bsab_pkg::REG_FORMAT_MODE] = 24'd3;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings first: loads outside the store are dropped.
        queue_load(1023, 0, 32'hFFFF_FFFF);
        queue_load(0, 1023, 32'h0000_0000);
        queue_load(128, 128, 32'h1234_5678);
        queue_blend(0, 0, 32'hFFFF_FFFF);
        queue_blend(1023, 1023, 32'h0000_0000);

        // Each blend mode, with opacity extremes, sub-pixel steps and edges.
        for (int m = 0; m < 4; m++)
        begin
            set_config(24'd32768, 24'd16384, 24'd127, 24'd0, 24'd0, 24'd255,
                       (m == 1) ? 24'd128 : (m == 2 ? 24'd0 : 24'd255), 24'(m));
            queue_load(0, 0, 32'hFF00_FF00);
            queue_load(0, 1, 32'h00FF_00FF);
            queue_blend(0, 0, 32'h80FF_0080);
            queue_blend(1, 3, 32'h0000_FFFF);
            queue_blend(1023, 511, 32'hFFFF_0000);
        end
        set_config(24'h800000, 24'd0, 24'd0, 24'd127, 24'd2, 24'd2, 24'd0, 24'd3);
        queue_blend(1, 0, 32'h0000_0000);
        queue_blend(0, 1023, 32'hFFFF_FFFF);

        for (int ph = 0; ph < 12 && queued_count < 650; ph++)
        begin
            set_config(pick_step(), pick_step(),
                       24'($urandom_range(0, 1) ? 0 : $urandom_range(0, 127)),
                       24'($urandom_range(0, 1) ? 0 : $urandom_range(0, 127)), pick_size(),
                       pick_size(),
                       24'($urandom_range(0, 2) == 0 ? 255 : ($urandom_range(0, 1) ? 0 :
                                                              $urandom_range(0, 255))),
                       24'($urandom_range(0, 3)));
            for (int n = 0; n < 50 && queued_count < 650; n++)
            begin
                if ($urandom_range(0, 9) < 2)
                begin
                    if ($urandom_range(0, 3) == 0)
                        queue_load($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
                    else
                        queue_load($urandom_range(0, 15), $urandom_range(0, 15), $urandom);
                end
                else
                begin
                    px = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
                    py = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
                    queue_blend(px, py, $urandom);
                end
            end
        end

        wait_idle();
        if (error_count == 0 && expected_pixels.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/bsab_pkg.sv
sv/bsab_if.sv
sv/bilinear_scale_alpha_blend.sv
tb/bilinear_scale_alpha_blend_tb.sv
